// File: src/bmrtc_pkg.sv
// Shared types, constants and small arithmetic helpers for the bank mapper
// with real-time clock. No dependencies; imported by every module of the block but the RAM.
package bmrtc_pkg;

  localparam int RamBytesDef = 32768;
  localparam int QueueDepth  = 4;

  // Input opcodes (in_tuser)
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // Address regions, decoded from bus_address[15:13]
  localparam logic [2:0] RegRamEn   = 3'd0;
  localparam logic [2:0] RegRomBank = 3'd1;
  localparam logic [2:0] RegBankSel = 3'd2;
  localparam logic [2:0] RegLatch   = 3'd3;
  localparam logic [2:0] RegExtArea = 3'd5;

  // Classified command kinds handed from front to back
  typedef enum logic [3:0] {
    K_NONE,
    K_SET_RAMEN,
    K_SET_ROMBANK,
    K_SET_BANKSEL,
    K_SET_LATCH,
    K_WR_EXT,
    K_RD_ROM,
    K_RD_EXT,
    K_RD_OPEN,
    K_TICK
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [14:0] addr;      // bus_address[14:0]
    logic [7:0]  data;      // write data; bank select already reduced mod 13
    logic [5:0]  sec_add;   // tick seconds split into sec/min/hour parts
    logic [5:0]  min_add;
    logic [4:0]  hour_add;
    logic        secs_nz;
  } cmd_t;

  localparam int SecsPerMin  = 60;
  localparam int MinPerHour  = 60;
  localparam int HoursPerDay = 24;
  localparam int BankSelMod  = 13;

  // Reciprocal multipliers: q = (x * K) >> S, exact over the stated x range
  localparam int Div60K16 = 69906;  // x < 2^16
  localparam int Div60S16 = 22;
  localparam int Div60K11 = 2185;   // x < 2^11
  localparam int Div60S11 = 17;
  localparam int Mod13K   = 316;    // x < 2^8
  localparam int Mod13S   = 12;

  localparam logic [3:0] RamEnKey    = 4'hA;
  localparam logic [6:0] RomBankMask = 7'h7F;
  localparam logic [7:0] OpenBus     = 8'hFF;
  localparam int         ClkRegs     = 5;
  localparam logic [3:0] RamSelLast  = 4'd3;
  localparam logic [3:0] ClkSelFirst = 4'd8;
  localparam logic [3:0] ClkSelLast  = 4'd12;
  localparam int         HaltBit     = 6;
  localparam int         CarryBit    = 7;

  // Largest quotients seen in the back-end carry chain (9-bit sums)
  localparam int Max60Q = 319 / SecsPerMin;
  localparam int Max24Q = 278 / HoursPerDay;

  typedef struct packed {
    logic [2:0] q;
    logic [5:0] r;
  } dm60_t;

  typedef struct packed {
    logic [3:0] q;
    logic [4:0] r;
  } dm24_t;

  // Narrow divide by 60: parallel threshold compares, x <= 319
  function automatic dm60_t divmod60(input logic [8:0] x);
    dm60_t res;
    res.q = '0;
    for (int k = 1; k <= Max60Q; k++) begin
      if (x >= 9'(k * SecsPerMin)) res.q = 3'(k);
    end
    res.r = 6'(x - 9'(res.q * SecsPerMin));
    return res;
  endfunction

  // Narrow divide by 24: parallel threshold compares, x <= 278
  function automatic dm24_t divmod24(input logic [8:0] x);
    dm24_t res;
    res.q = '0;
    for (int k = 1; k <= Max24Q; k++) begin
      if (x >= 9'(k * HoursPerDay)) res.q = 4'(k);
    end
    res.r = 5'(x - 9'(res.q * HoursPerDay));
    return res;
  endfunction

endpackage

// File: src/bmrtc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bmrtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    if (re) rdata <= mem_r[addr];
  end

endmodule

// File: src/bmrtc_front.sv
// Front end: accepts input transfers, decodes the address region and splits
// tick seconds into second/minute/hour parts. Depends on bmrtc_pkg.
module bmrtc_front
  import bmrtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  logic        f1_valid_r, f1_valid_nxt;
  kind_t       f1_kind_r, f1_kind_nxt;
  logic [14:0] f1_addr_r;
  logic [7:0]  f1_data_r;
  logic [15:0] f1_secs_r;
  logic [10:0] f1_q1_r;

  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic [15:0] elapsed_seconds;
  logic [32:0] q1_prod;
  logic [22:0] q2_prod;
  logic [16:0] m13_prod;
  logic [4:0]  q2;
  logic [4:0]  m13_q;
  logic [3:0]  m13_r;

  assign bus_address     = in_tdata[15:0];
  assign write_data      = in_tdata[23:16];
  assign elapsed_seconds = in_tdata[39:24];

  assign in_tready = !f1_valid_r || cmd_ready;

  // Region decode
  always_comb begin
    f1_kind_nxt = K_NONE;
    case (opcode_t'(in_tuser))
      OP_WRITE: begin
        case (bus_address[15:13])
          RegRamEn:   f1_kind_nxt = K_SET_RAMEN;
          RegRomBank: f1_kind_nxt = K_SET_ROMBANK;
          RegBankSel: f1_kind_nxt = K_SET_BANKSEL;
          RegLatch:   f1_kind_nxt = K_SET_LATCH;
          RegExtArea: f1_kind_nxt = K_WR_EXT;
          default:    f1_kind_nxt = K_NONE;
        endcase
      end
      OP_READ: begin
        if (!bus_address[15])                    f1_kind_nxt = K_RD_ROM;
        else if (bus_address[15:13] == RegExtArea) f1_kind_nxt = K_RD_EXT;
        else                                     f1_kind_nxt = K_RD_OPEN;
      end
      OP_TICK: f1_kind_nxt = K_TICK;
      default: f1_kind_nxt = K_NONE;
    endcase
  end

  // seconds / 60 over the full 16-bit range
  assign q1_prod = 33'(elapsed_seconds) * 33'(Div60K16);

  always_comb begin
    f1_valid_nxt = f1_valid_r;
    if (in_tready) f1_valid_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
    end
    if (in_tready && in_tvalid) begin
      f1_kind_r <= f1_kind_nxt;
      f1_addr_r <= bus_address[14:0];
      f1_data_r <= write_data;
      f1_secs_r <= elapsed_seconds;
      f1_q1_r   <= q1_prod[Div60S16+10:Div60S16];
    end
  end

  // minutes / 60 (result <= 18, so it is the hour part), and data mod 13
  assign q2_prod  = 23'(f1_q1_r) * 23'(Div60K11);
  assign q2       = q2_prod[Div60S11+4:Div60S11];
  assign m13_prod = 17'(f1_data_r) * 17'(Mod13K);
  assign m13_q    = m13_prod[Mod13S+4:Mod13S];
  assign m13_r    = 4'(f1_data_r - 8'(m13_q * BankSelMod));

  assign cmd_valid = f1_valid_r;

  always_comb begin
    cmd.kind     = f1_kind_r;
    cmd.addr     = f1_addr_r;
    cmd.data     = (f1_kind_r == K_SET_BANKSEL) ? {4'b0, m13_r} : f1_data_r;
    cmd.sec_add  = 6'(f1_secs_r - 16'(f1_q1_r * SecsPerMin));
    cmd.min_add  = 6'(f1_q1_r - 11'(q2 * MinPerHour));
    cmd.hour_add = q2;
    cmd.secs_nz  = (f1_secs_r != '0);
  end

endmodule

// File: src/bmrtc_queue.sv
// Short command queue between front and back ends.
// Depends on bmrtc_pkg (cmd_t, QueueDepth).
module bmrtc_queue
  import bmrtc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int QAw = $clog2(QueueDepth);

  cmd_t           mem_r [QueueDepth];
  logic [QAw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAw:0]   count_r, count_nxt;
  logic           push, pop;

  assign push_ready = (count_r != (QAw+1)'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAw+1)'(push) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// File: src/bmrtc_back.sv
// Back end: mapper registers, clock registers, banked RAM and output register.
// Depends on bmrtc_pkg and bmrtc_ram.
module bmrtc_back
  import bmrtc_pkg::*;
#(
  parameter int RAM_BYTES = RamBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tuser
);

  localparam bit          HasRam  = (RAM_BYTES > 0);
  localparam int          RamDepth = (RAM_BYTES > 1) ? RAM_BYTES : 2;
  localparam int          RamAw   = $clog2(RamDepth);
  localparam logic [14:0] RamMask = 15'((RAM_BYTES > 0) ? RAM_BYTES - 1 : 0);

  // Mapper state
  logic [6:0] rom_bank_r, rom_bank_nxt;
  logic       ram_en_r, ram_en_nxt;
  logic [3:0] sel_r, sel_nxt;
  logic       latch_r, latch_nxt;
  logic [7:0] clk_regs_r [ClkRegs];
  logic [7:0] clk_regs_nxt [ClkRegs];
  logic [7:0] latched_r [ClkRegs];
  logic [7:0] latched_nxt [ClkRegs];

  // Output register
  logic        y_valid_r, y_valid_nxt;
  logic [7:0]  y_byte_r, y_byte_nxt;
  logic        y_fetch_r, y_fetch_nxt;
  logic [20:0] y_addr_r, y_addr_nxt;
  logic        y_use_ram_r, y_use_ram_nxt;

  logic             pop;
  logic             sel_is_ram, sel_is_clk;
  logic [2:0]       clk_idx;
  logic [14:0]      ram_idx;
  logic             ram_we, ram_re;
  logic [RamAw-1:0] ram_addr;
  logic [7:0]       ram_rdata;

  // Tick carry chain
  logic [8:0] sum_s, sum_m, sum_h;
  logic [9:0] sum_d;
  dm60_t      dm_s, dm_m;
  dm24_t      dm_h;

  assign cmd_ready  = !y_valid_r || out_tready;
  assign pop        = cmd_valid && cmd_ready;
  assign sel_is_ram = (sel_r <= RamSelLast);
  assign sel_is_clk = sel_r inside {[ClkSelFirst:ClkSelLast]};
  assign clk_idx    = 3'(sel_r - ClkSelFirst);
  assign ram_idx    = {sel_r[1:0], cmd.addr[12:0]} & RamMask;
  assign ram_addr   = ram_idx[RamAw-1:0];

  assign ram_we = pop && (cmd.kind == K_WR_EXT) && ram_en_r && HasRam && sel_is_ram;
  assign ram_re = pop && (cmd.kind == K_RD_EXT) && ram_en_r && HasRam && sel_is_ram;

  bmrtc_ram #(
    .WIDTH(8),
    .DEPTH(RamDepth)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(cmd.data),
    .rdata(ram_rdata)
  );

  always_comb begin
    sum_s = 9'(clk_regs_r[0]) + 9'(cmd.sec_add);
    dm_s  = divmod60(sum_s);
    sum_m = 9'(clk_regs_r[1]) + 9'(cmd.min_add) + 9'(dm_s.q);
    dm_m  = divmod60(sum_m);
    sum_h = 9'(clk_regs_r[2]) + 9'(cmd.hour_add) + 9'(dm_m.q);
    dm_h  = divmod24(sum_h);
    sum_d = 10'({clk_regs_r[4][0], clk_regs_r[3]}) + 10'(dm_h.q);
  end

  always_comb begin
    rom_bank_nxt  = rom_bank_r;
    ram_en_nxt    = ram_en_r;
    sel_nxt       = sel_r;
    latch_nxt     = latch_r;
    clk_regs_nxt  = clk_regs_r;
    latched_nxt   = latched_r;
    y_valid_nxt   = y_valid_r;
    y_byte_nxt    = y_byte_r;
    y_fetch_nxt   = y_fetch_r;
    y_addr_nxt    = y_addr_r;
    y_use_ram_nxt = y_use_ram_r;

    if (out_tready) y_valid_nxt = 1'b0;

    if (pop) begin
      y_valid_nxt   = 1'b1;
      y_byte_nxt    = '0;
      y_fetch_nxt   = 1'b0;
      y_addr_nxt    = '0;
      y_use_ram_nxt = 1'b0;
      case (cmd.kind)
        K_SET_RAMEN:   ram_en_nxt = (cmd.data[3:0] == RamEnKey);
        K_SET_ROMBANK: begin
          rom_bank_nxt = cmd.data[6:0] & RomBankMask;
          if (rom_bank_nxt == '0) rom_bank_nxt = 7'd1;
        end
        K_SET_BANKSEL: sel_nxt = cmd.data[3:0];
        K_SET_LATCH: begin
          // rising latch level snapshots the running clock
          if (!latch_r && cmd.data[0]) latched_nxt = clk_regs_r;
          latch_nxt = cmd.data[0];
        end
        K_WR_EXT: begin
          if (ram_en_r && HasRam && sel_is_clk) clk_regs_nxt[clk_idx] = cmd.data;
        end
        K_RD_ROM: begin
          y_fetch_nxt = 1'b1;
          y_addr_nxt  = {(cmd.addr[14] ? rom_bank_r : 7'd0), cmd.addr[13:0]};
        end
        K_RD_EXT: begin
          y_byte_nxt = OpenBus;
          if (ram_en_r) begin
            if (sel_is_ram && HasRam) y_use_ram_nxt = 1'b1;
            else if (sel_is_clk)      y_byte_nxt = latched_r[clk_idx];
          end
        end
        K_RD_OPEN: y_byte_nxt = OpenBus;
        K_TICK: begin
          if (cmd.secs_nz && !clk_regs_r[4][HaltBit]) begin
            clk_regs_nxt[0] = 8'(dm_s.r);
            clk_regs_nxt[1] = 8'(dm_m.r);
            clk_regs_nxt[2] = 8'(dm_h.r);
            clk_regs_nxt[3] = sum_d[7:0];
            clk_regs_nxt[4] = {clk_regs_r[4][CarryBit] | sum_d[9],
                               clk_regs_r[4][6:1], sum_d[8]};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= 7'd1;
      ram_en_r   <= 1'b0;
      sel_r      <= '0;
      latch_r    <= 1'b0;
      y_valid_r  <= 1'b0;
      for (int i = 0; i < ClkRegs; i++) begin
        clk_regs_r[i] <= '0;
        latched_r[i]  <= '0;
      end
    end else begin
      rom_bank_r <= rom_bank_nxt;
      ram_en_r   <= ram_en_nxt;
      sel_r      <= sel_nxt;
      latch_r    <= latch_nxt;
      y_valid_r  <= y_valid_nxt;
      clk_regs_r <= clk_regs_nxt;
      latched_r  <= latched_nxt;
    end
    y_byte_r    <= y_byte_nxt;
    y_fetch_r   <= y_fetch_nxt;
    y_addr_r    <= y_addr_nxt;
    y_use_ram_r <= y_use_ram_nxt;
  end

  // RAM read data is held by the RAM until the next read, which can only
  // happen once this result has left the output register.
  assign out_tvalid = y_valid_r;
  assign out_tuser  = y_fetch_r;
  assign out_tdata  = {3'b0, y_addr_r, (y_use_ram_r ? ram_rdata : y_byte_r)};

endmodule

// File: src/bank_mapper_with_rtc_unit.sv
// Bank mapper with real-time clock: one result transfer per input transfer.
// Throughput: one transfer per cycle for every opcode, ticks included, while
//   the output side does not stall; the tick split into second/minute/hour
//   parts is done ahead of the state.
// Path: the result passes the front register, the command queue and the
//   output register in that order, and is held while the output side stalls.
// Reset: synchronous, active low; mapper and clock registers take their reset
//   values, RAM contents stay undefined until written (no clearing pass).
module bank_mapper_with_rtc_unit
  import bmrtc_pkg::*;
#(
  parameter int RAM_BYTES = RamBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [15:0] bus_address, [23:16] write_data,
                                  // [39:24] elapsed_seconds
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] read_byte, [28:8] rom_address,
                                  // [31:29] zero
  output logic        out_tuser   // [0] rom_fetch
);

  // Front -> queue
  logic f_valid, f_ready;
  cmd_t f_cmd;
  // Queue -> back
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // Front end: decode and tick-seconds split, one register stage.
  bmrtc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd      (f_cmd)
  );

  // Decouples input acceptance from output stalls.
  bmrtc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_cmd  (f_cmd),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_cmd   (q_cmd)
  );

  // Back end: executes one command per cycle against the mapper state while its output register is free or drained.
  bmrtc_back #(
    .RAM_BYTES(RAM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Every accepted transfer shows up in the front register next cycle.
  a_front_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> f_valid)
    else $error("accepted transfer did not reach front register");

  // Front holds its command while the queue is full.
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !f_ready |=> f_valid && $stable(f_cmd))
    else $error("front command lost while queue full");

  // Reset empties the queue and the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !q_valid && !out_tvalid)
    else $error("pipeline not empty after reset");

endmodule
